// ----- src/sfx_pkg.sv -----
package sfx_pkg;

   localparam int NAME_CHARS_DEF    = 47;
   localparam int VERSION_CHARS_DEF = 31;
   localparam int QUEUE_DEPTH       = 4;
   localparam int SLOTS             = 4;

   localparam logic [2:0] FID_BIOS_VENDOR   = 3'd0;
   localparam logic [2:0] FID_BIOS_VERSION  = 3'd1;
   localparam logic [2:0] FID_BOARD_VENDOR  = 3'd2;
   localparam logic [2:0] FID_BOARD_PRODUCT = 3'd3;
   localparam logic [2:0] FID_UUID          = 3'd4;

   localparam logic [7:0] TYPE_BIOS     = 8'h00;
   localparam logic [7:0] TYPE_SYSTEM   = 8'h01;
   localparam logic [7:0] TYPE_BOARD    = 8'h02;
   localparam logic [7:0] LEN_HEADER    = 8'h04;
   localparam logic [7:0] LEN_UUID_MIN  = 8'h18;
   localparam logic [7:0] OFS_IDX1      = 8'h04;
   localparam logic [7:0] OFS_IDX2      = 8'h05;
   localparam logic [7:0] OFS_UUID_LO   = 8'h08;
   localparam logic [7:0] OFS_UUID_HI   = 8'h17;
   localparam logic [7:0] OFS_TYPE      = 8'h00;
   localparam logic [7:0] OFS_LEN       = 8'h01;
   localparam logic [7:0] OFS_HDR_LAST  = 8'h03;
   localparam logic [5:0] CHAR_COUNT_MAX = 6'd63;

   localparam logic [7:0] DASH_CHAR     = 8'h2d;
   localparam logic [5:0] UUID_LAST_POS = 6'd35;
   localparam logic [5:0] UUID_DASH0    = 6'd8;
   localparam logic [5:0] UUID_DASH1    = 6'd13;
   localparam logic [5:0] UUID_DASH2    = 6'd18;
   localparam logic [5:0] UUID_DASH3    = 6'd23;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_FORMAT  = 2'd1,
      PH_STRINGS = 2'd2,
      PH_IGNORE  = 2'd3
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] fid;
      logic [7:0] ch;
      logic       last;
      logic       cut;
   } slot_type;

   // slots 0 and 1: string characters, slots 2 and 3: table-end flush
   typedef struct packed {
      logic                 uuid;
      slot_type [SLOTS-1:0] slots;
   } entry_type;

   typedef struct packed {
      logic       en;
      logic [3:0] idx;
      logic [7:0] data;
   } uuid_wr_type;

   function automatic logic [3:0] uuid_order(input logic [3:0] i);
      logic [3:0] r;
      case (i)
         4'd0:    r = 4'd3;
         4'd1:    r = 4'd2;
         4'd2:    r = 4'd1;
         4'd3:    r = 4'd0;
         4'd4:    r = 4'd5;
         4'd5:    r = 4'd4;
         4'd6:    r = 4'd7;
         4'd7:    r = 4'd6;
         default: r = i;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
   endfunction

endpackage

// ----- src/smbios_table_field_extractor.sv -----
// smbios structure table field extractor
// req channel: one table byte per item, tlast on the final byte of the table;
//   after that byte every parse state but the uuid busy flag returns to its reset value
// rsp channel: one extracted character per item, tlast on the last character of
//   a field; tuser carries the field id and the cut flag (set when the table
//   ended inside the string, the consumer then drops the field)
// a released result is registered in the queue and then in the output register; string
//   characters are held back one byte so the final one can carry tlast
// throughput: one byte per cycle while each byte yields at most one character and
//   the receiver is ready, no uuid going out; a byte yielding more characters keeps the
//   emitter busy, the 4-entry queue between parser and emitter absorbing short bursts
// the uuid is sent as a 36-character burst of hex text; req_tready stays low from
//   that byte until the last uuid character is loaded into the output register
// reset: synchronous, clears the parser, queue and output valid; no clearing
//   pass is needed
// a stalled receiver holds the output register; the parser keeps taking bytes
//   until the queue fills
module smbios_table_field_extractor #(
   parameter int NAME_CHARS    = sfx_pkg::NAME_CHARS_DEF,
   parameter int VERSION_CHARS = sfx_pkg::VERSION_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // table_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // char_byte
   output logic       rsp_tlast,   // last_char
   output logic [3:0] rsp_tuser    // field_id [2:0], cut_short [3]
);

   sfx_pkg::entry_type   push_entry, head;
   sfx_pkg::uuid_wr_type uuid_wr;
   logic push, pop, full, head_valid, uuid_done;

   // parser: walks headers, formatted area and string set
   sfx_front #(
      .NAME_CHARS    (NAME_CHARS),
      .VERSION_CHARS (VERSION_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (full),
      .uuid_done  (uuid_done),
      .push       (push),
      .entry      (push_entry),
      .uuid_wr    (uuid_wr)
   );

   // decoupling queue of per-byte emit lists
   sfx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // emitter: one character per cycle into the output register while the receiver is not stalling
   sfx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .uuid_done  (uuid_done),
      .uuid_wr    (uuid_wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");

   // emitter only retires an entry that exists
   a_pop_valid: assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from empty queue");

   // parser stalls while a uuid burst is still going out
   a_uuid_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:0] == sfx_pkg::FID_UUID && !rsp_tlast) |-> !req_tready)
      else $error("input taken during uuid burst");

endmodule

// ----- src/sfx_front.sv -----
module sfx_front #(
   parameter int NAME_CHARS    = sfx_pkg::NAME_CHARS_DEF,
   parameter int VERSION_CHARS = sfx_pkg::VERSION_CHARS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  queue_full,
   input  logic                  uuid_done,
   output logic                  push,
   output sfx_pkg::entry_type    entry,
   output sfx_pkg::uuid_wr_type  uuid_wr
);

   localparam logic [5:0] NAME_LIM = 6'(NAME_CHARS);
   localparam logic [5:0] VER_LIM  = 6'(VERSION_CHARS);

   sfx_pkg::phase_type phase_ff, phase_in;
   logic [7:0] off_ff, off_in, stype_ff, stype_in, slen_ff, slen_in;
   logic [7:0] idx1_ff, idx1_in, idx2_ff, idx2_in, strnum_ff, strnum_in;
   logic [7:0] held_ff, held_in;
   logic [5:0] count_ff, count_in;
   logic       heldv_ff, heldv_in, prevzero_ff, prevzero_in;
   logic [4:0] filled_ff, filled_in;
   logic [1:0] target_ff, target_in;
   logic       all0_ff, all0_in, allf_ff, allf_in;
   logic       busy_ff, busy_in;
   logic       accept;
   logic [2:0] fid [2];
   logic [5:0] lim [2];
   logic [1:0] tgt;
   logic [7:0] b;

   assign req_tready = !queue_full && !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign push       = accept && (entry.uuid || entry.slots[0].valid || entry.slots[1].valid
                                 || entry.slots[2].valid || entry.slots[3].valid);

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         fid[t] = ((stype_ff == sfx_pkg::TYPE_BIOS) ? sfx_pkg::FID_BIOS_VENDOR
                                                    : sfx_pkg::FID_BOARD_VENDOR) + 3'(t);
         lim[t] = (fid[t] == sfx_pkg::FID_BIOS_VERSION) ? VER_LIM : NAME_LIM;
      end
   end

   always_comb begin
      phase_in = phase_ff; off_in = off_ff; stype_in = stype_ff; slen_in = slen_ff;
      idx1_in = idx1_ff; idx2_in = idx2_ff; strnum_in = strnum_ff; held_in = held_ff;
      count_in = count_ff; heldv_in = heldv_ff; prevzero_in = prevzero_ff;
      filled_in = filled_ff; target_in = target_ff; all0_in = all0_ff; allf_in = allf_ff;
      busy_in = busy_ff && !uuid_done;
      entry = '0;
      uuid_wr = '0;
      tgt = target_ff;
      if (accept) begin
         case (phase_ff)
            sfx_pkg::PH_HEADER: begin
               if (off_ff == sfx_pkg::OFS_TYPE) begin
                  stype_in = b; idx1_in = '0; idx2_in = '0;
               end else if (off_ff == sfx_pkg::OFS_LEN) begin
                  slen_in = b;
               end
               if (off_ff == sfx_pkg::OFS_HDR_LAST) begin
                  if (slen_ff < sfx_pkg::LEN_HEADER) begin
                     phase_in = sfx_pkg::PH_IGNORE;
                  end else if (slen_ff == sfx_pkg::LEN_HEADER) begin
                     phase_in = sfx_pkg::PH_STRINGS;
                  end else begin
                     phase_in = sfx_pkg::PH_FORMAT;
                  end
                  strnum_in = 8'd1; count_in = '0; heldv_in = 1'b0;
                  target_in = '0; prevzero_in = 1'b0;
               end
               off_in = off_ff + 8'd1;
            end
            sfx_pkg::PH_FORMAT: begin
               if (off_ff == sfx_pkg::OFS_IDX1) begin
                  idx1_in = b;
               end else if (off_ff == sfx_pkg::OFS_IDX2) begin
                  idx2_in = b;
               end
               if (stype_ff == sfx_pkg::TYPE_SYSTEM && off_ff >= sfx_pkg::OFS_UUID_LO
                   && off_ff <= sfx_pkg::OFS_UUID_HI) begin
                  uuid_wr.en   = 1'b1;
                  uuid_wr.idx  = 4'(off_ff - sfx_pkg::OFS_UUID_LO);
                  uuid_wr.data = b;
                  if (off_ff == sfx_pkg::OFS_UUID_LO) begin
                     all0_in = (b == 8'h00); allf_in = (b == 8'hff);
                  end else begin
                     all0_in = all0_ff && (b == 8'h00); allf_in = allf_ff && (b == 8'hff);
                  end
               end
               if ({1'b0, off_ff} + 9'd1 >= {1'b0, slen_ff}) begin
                  if (stype_ff == sfx_pkg::TYPE_SYSTEM && slen_ff >= sfx_pkg::LEN_UUID_MIN
                      && !filled_ff[sfx_pkg::FID_UUID] && !(all0_in || allf_in)) begin
                     entry.uuid = 1'b1;
                     filled_in[sfx_pkg::FID_UUID] = 1'b1;
                     busy_in = 1'b1;
                  end
                  phase_in = sfx_pkg::PH_STRINGS;
               end
               off_in = off_ff + 8'd1;
            end
            sfx_pkg::PH_STRINGS: begin
               if (b != 8'h00) begin
                  prevzero_in = 1'b0;
                  if (count_ff == '0) begin
                     tgt = '0;
                     if (stype_ff <= sfx_pkg::TYPE_BOARD && strnum_ff != '0) begin
                        if (idx1_ff != '0 && idx1_ff == strnum_ff && !filled_ff[fid[0]])
                           tgt[0] = 1'b1;
                        if (idx2_ff != '0 && idx2_ff == strnum_ff && !filled_ff[fid[1]])
                           tgt[1] = 1'b1;
                     end
                  end
                  if (heldv_ff) begin
                     for (int t = 0; t < 2; t++) begin
                        if (tgt[t] && count_ff <= lim[t]) begin
                           entry.slots[t].valid = 1'b1;
                           entry.slots[t].fid   = fid[t];
                           entry.slots[t].ch    = held_ff;
                           entry.slots[t].last  = (count_ff == lim[t]);
                        end
                     end
                  end
                  if (count_ff != sfx_pkg::CHAR_COUNT_MAX) begin
                     count_in = count_ff + 6'd1; held_in = b; heldv_in = 1'b1;
                  end else begin
                     heldv_in = 1'b0;
                  end
                  target_in = tgt;
               end else if (prevzero_ff) begin
                  phase_in = sfx_pkg::PH_HEADER; off_in = '0; prevzero_in = 1'b0;
               end else begin
                  for (int t = 0; t < 2; t++) begin
                     if (heldv_ff && target_ff[t] && count_ff <= lim[t]) begin
                        entry.slots[t].valid = 1'b1;
                        entry.slots[t].fid   = fid[t];
                        entry.slots[t].ch    = held_ff;
                        entry.slots[t].last  = 1'b1;
                     end
                     if (target_ff[t]) filled_in[fid[t]] = 1'b1;
                  end
                  if (strnum_ff != '0) strnum_in = strnum_ff + 8'd1;
                  count_in = '0; heldv_in = 1'b0; target_in = '0; prevzero_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (req_tlast) begin
            // table ended inside a captured string
            if (phase_in == sfx_pkg::PH_STRINGS && count_in != '0) begin
               for (int t = 0; t < 2; t++) begin
                  if (target_in[t]) begin
                     entry.slots[t+2].valid = 1'b1;
                     entry.slots[t+2].fid   = fid[t];
                     entry.slots[t+2].ch    = (heldv_in && count_in <= lim[t]) ? held_in : 8'h00;
                     entry.slots[t+2].last  = 1'b1;
                     entry.slots[t+2].cut   = 1'b1;
                  end
               end
            end
            phase_in = sfx_pkg::PH_HEADER; off_in = '0; stype_in = '0; slen_in = '0;
            idx1_in = '0; idx2_in = '0; strnum_in = '0; held_in = '0; count_in = '0;
            heldv_in = 1'b0; prevzero_in = 1'b0; filled_in = '0; target_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfx_pkg::PH_HEADER; off_ff <= '0; stype_ff <= '0; slen_ff <= '0;
         idx1_ff <= '0; idx2_ff <= '0; strnum_ff <= '0; held_ff <= '0; count_ff <= '0;
         heldv_ff <= 1'b0; prevzero_ff <= 1'b0; filled_ff <= '0; target_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; off_ff <= off_in; stype_ff <= stype_in; slen_ff <= slen_in;
         idx1_ff <= idx1_in; idx2_ff <= idx2_in; strnum_ff <= strnum_in; held_ff <= held_in;
         count_ff <= count_in; heldv_ff <= heldv_in; prevzero_ff <= prevzero_in;
         filled_ff <= filled_in; target_ff <= target_in; busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      all0_ff <= all0_in;
      allf_ff <= allf_in;
   end

endmodule

// ----- src/sfx_queue.sv -----
module sfx_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfx_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output sfx_pkg::entry_type head
);

   localparam int PTR_W = $clog2(sfx_pkg::QUEUE_DEPTH);

   sfx_pkg::entry_type mem_ff [sfx_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == (PTR_W+1)'(sfx_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

// ----- src/sfx_back.sv -----
module sfx_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  sfx_pkg::entry_type   head,
   output logic                 pop,
   output logic                 uuid_done,
   input  sfx_pkg::uuid_wr_type uuid_wr,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic [3:0]           rsp_tuser
);

   logic [7:0] uuid_ff [16];
   logic [1:0] slot_ff, slot_in;
   logic [5:0] upos_ff, upos_in;
   logic       valid_ff, valid_in, last_ff, last_in, cut_ff, cut_in;
   logic [2:0] fid_ff, fid_in;
   logic [7:0] ch_ff, ch_in;
   logic       can_load, found, more, dash;
   logic [1:0] sel;
   logic [2:0] dcount;
   logic [5:0] k;
   logic [7:0] ub;

   assign can_load   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = ch_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {cut_ff, fid_ff};

   // next valid slot at or after the current one
   always_comb begin
      found = 1'b0; more = 1'b0; sel = '0;
      for (int i = 0; i < sfx_pkg::SLOTS; i++) begin
         if (head.slots[i].valid && 2'(i) >= slot_ff) begin
            if (found) more = 1'b1;
            else begin
               found = 1'b1; sel = 2'(i);
            end
         end
      end
   end

   // uuid text position to byte and nibble
   always_comb begin
      dash = (upos_ff == sfx_pkg::UUID_DASH0) || (upos_ff == sfx_pkg::UUID_DASH1)
          || (upos_ff == sfx_pkg::UUID_DASH2) || (upos_ff == sfx_pkg::UUID_DASH3);
      dcount = 3'(upos_ff > sfx_pkg::UUID_DASH0) + 3'(upos_ff > sfx_pkg::UUID_DASH1)
             + 3'(upos_ff > sfx_pkg::UUID_DASH2) + 3'(upos_ff > sfx_pkg::UUID_DASH3);
      k  = upos_ff - {3'b000, dcount};
      ub = uuid_ff[sfx_pkg::uuid_order(k[4:1])];
   end

   always_comb begin
      slot_in = slot_ff; upos_in = upos_ff;
      valid_in = valid_ff && !rsp_tready;
      fid_in = fid_ff; ch_in = ch_ff; last_in = last_ff; cut_in = cut_ff;
      pop = 1'b0; uuid_done = 1'b0;
      if (head_valid && can_load) begin
         if (head.uuid) begin
            valid_in = 1'b1;
            fid_in   = sfx_pkg::FID_UUID;
            ch_in    = dash ? sfx_pkg::DASH_CHAR
                            : sfx_pkg::hex_char(k[0] ? ub[3:0] : ub[7:4]);
            last_in  = (upos_ff == sfx_pkg::UUID_LAST_POS);
            cut_in   = 1'b0;
            if (upos_ff == sfx_pkg::UUID_LAST_POS) begin
               pop = 1'b1; uuid_done = 1'b1; upos_in = '0;
            end else begin
               upos_in = upos_ff + 6'd1;
            end
         end else begin
            if (found) begin
               valid_in = 1'b1;
               fid_in   = head.slots[sel].fid;
               ch_in    = head.slots[sel].ch;
               last_in  = head.slots[sel].last;
               cut_in   = head.slots[sel].cut;
            end
            if (!more) begin
               pop = 1'b1; slot_in = '0;
            end else begin
               slot_in = sel + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0; upos_ff <= '0; valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in; upos_ff <= upos_in; valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fid_ff <= fid_in; ch_ff <= ch_in; last_ff <= last_in; cut_ff <= cut_in;
      if (uuid_wr.en) uuid_ff[uuid_wr.idx] <= uuid_wr.data;
   end

endmodule

// ----- tb/sv/smbios_table_field_extractor_test.sv -----
module smbios_table_field_extractor_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NAME_LIM = sfx_pkg::NAME_CHARS_DEF;
   localparam int VER_LIM  = sfx_pkg::VERSION_CHARS_DEF;

   // one extracted character as the receiver sees it
   typedef struct packed {
      logic [2:0] fid;
      logic [7:0] ch;
      logic       last;
      logic       cut;
   } char_item_type;

   // one table byte as offered to the block
   typedef struct packed {
      logic [7:0] data;
      logic       tend;
   } byte_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // data_byte
   logic       req_tlast = 1'b0;    // table_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // char_byte
   logic       rsp_tlast;           // last_char
   logic [3:0] rsp_tuser;           // field_id [2:0], cut_short [3]

   smbios_table_field_extractor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // parser shadow state
   // ---------------------------------------------------------------------------
   sfx_pkg::phase_type ph;
   logic [7:0] ofs, stype, slen, idx_a, idx_b, str_no;
   logic [5:0] n_chars;
   logic [7:0] held;
   logic       held_ok;
   logic [4:0] filled;
   logic [1:0] target;
   logic       was_zero;
   logic [7:0] uuid_raw [16];

   char_item_type pending_chars [$];
   int errors = 0;
   int send_idle = 14;
   int recv_idle = 71;
   bit hold_off = 1'b0;

   function automatic logic [2:0] fid_for(input int t);
      return ((stype == sfx_pkg::TYPE_BIOS) ? sfx_pkg::FID_BIOS_VENDOR
                                            : sfx_pkg::FID_BOARD_VENDOR) + 3'(t);
   endfunction

   function automatic int limit_for(input logic [2:0] f);
      return (f == sfx_pkg::FID_BIOS_VERSION) ? VER_LIM : NAME_LIM;
   endfunction

   task automatic push_char(input logic [2:0] f, input logic [7:0] c,
                            input logic l, input logic k);
      char_item_type e;
      e.fid = f; e.ch = c; e.last = l; e.cut = k;
      pending_chars.push_back(e);
   endtask

   task automatic clear_parser();
      ph = sfx_pkg::PH_HEADER; ofs = 0; stype = 0; slen = 0; idx_a = 0; idx_b = 0;
      str_no = 0; n_chars = 0; held = 0; held_ok = 0; filled = 0; target = 0;
      was_zero = 0;
      foreach (uuid_raw[i]) uuid_raw[i] = 8'h00;
   endtask

   task automatic queue_uuid_text();
      bit all0, allf;
      logic [7:0] b;
      string hx;
      int pos;
      all0 = 1; allf = 1; hx = "0123456789abcdef"; pos = 0;
      foreach (uuid_raw[i]) begin
         if (uuid_raw[i] != 8'h00) all0 = 0;
         if (uuid_raw[i] != 8'hff) allf = 0;
      end
      if (all0 || allf) return;
      for (int i = 0; i < 16; i++) begin
         // leading three groups are little-endian on the wire
         b = uuid_raw[(i < 4) ? 3 - i : (i < 6) ? 9 - i : (i < 8) ? 13 - i : i];
         if (i == 4 || i == 6 || i == 8 || i == 10) begin
            push_char(sfx_pkg::FID_UUID, sfx_pkg::DASH_CHAR, 0, 0);
            pos++;
         end
         push_char(sfx_pkg::FID_UUID, hx[b[7:4]], 0, 0);
         pos += 2;
         push_char(sfx_pkg::FID_UUID, hx[b[3:0]], pos == 36, 0);
      end
      filled[sfx_pkg::FID_UUID] = 1'b1;
   endtask

   task automatic string_byte(input logic [7:0] b);
      logic [2:0] f;
      if (b != 0) begin
         was_zero = 0;
         if (n_chars == 0) begin
            target = 0;
            if (stype <= sfx_pkg::TYPE_BOARD && str_no != 0) begin
               if (idx_a != 0 && idx_a == str_no && !filled[fid_for(0)]) target[0] = 1;
               if (idx_b != 0 && idx_b == str_no && !filled[fid_for(1)]) target[1] = 1;
            end
         end
         if (held_ok)
            for (int t = 0; t < 2; t++) begin
               f = fid_for(t);
               if (!target[t]) continue;
               if (n_chars < limit_for(f)) push_char(f, held, 0, 0);
               else if (n_chars == limit_for(f)) push_char(f, held, 1, 0);
            end
         if (n_chars < sfx_pkg::CHAR_COUNT_MAX) begin
            n_chars++; held = b; held_ok = 1;
         end else
            held_ok = 0;
         return;
      end
      // double zero closes the string set
      if (was_zero) begin
         ph = sfx_pkg::PH_HEADER; ofs = 0; was_zero = 0;
         return;
      end
      if (held_ok)
         for (int t = 0; t < 2; t++) begin
            f = fid_for(t);
            if (target[t] && n_chars <= limit_for(f)) push_char(f, held, 1, 0);
         end
      for (int t = 0; t < 2; t++)
         if (target[t]) filled[fid_for(t)] = 1'b1;
      if (str_no != 0) str_no++;
      n_chars = 0; held_ok = 0; target = 0; was_zero = 1;
   endtask

   // works out the characters one accepted table byte releases
   task automatic predict_chars(input byte_item_type it);
      logic [2:0] f;
      case (ph)
         sfx_pkg::PH_HEADER: begin
            if (ofs == sfx_pkg::OFS_TYPE) begin
               stype = it.data; idx_a = 0; idx_b = 0;
            end else if (ofs == sfx_pkg::OFS_LEN)
               slen = it.data;
            if (ofs == sfx_pkg::OFS_HDR_LAST) begin
               if (slen < sfx_pkg::LEN_HEADER) ph = sfx_pkg::PH_IGNORE;
               else if (slen == sfx_pkg::LEN_HEADER) ph = sfx_pkg::PH_STRINGS;
               else ph = sfx_pkg::PH_FORMAT;
               str_no = 1; n_chars = 0; held_ok = 0; target = 0; was_zero = 0;
            end
            ofs++;
         end
         sfx_pkg::PH_FORMAT: begin
            if (ofs == sfx_pkg::OFS_IDX1) idx_a = it.data;
            else if (ofs == sfx_pkg::OFS_IDX2) idx_b = it.data;
            if (stype == sfx_pkg::TYPE_SYSTEM && ofs >= sfx_pkg::OFS_UUID_LO
                && ofs <= sfx_pkg::OFS_UUID_HI)
               uuid_raw[ofs - sfx_pkg::OFS_UUID_LO] = it.data;
            if (int'(ofs) + 1 >= int'(slen)) begin
               if (stype == sfx_pkg::TYPE_SYSTEM && slen >= sfx_pkg::LEN_UUID_MIN
                   && !filled[sfx_pkg::FID_UUID])
                  queue_uuid_text();
               ph = sfx_pkg::PH_STRINGS;
            end
            ofs++;
         end
         sfx_pkg::PH_STRINGS: string_byte(it.data);
         default: ;
      endcase
      if (it.tend) begin
         // table ended inside a captured string
         if (ph == sfx_pkg::PH_STRINGS && n_chars > 0)
            for (int t = 0; t < 2; t++) begin
               f = fid_for(t);
               if (!target[t]) continue;
               if (held_ok && n_chars <= limit_for(f)) push_char(f, held, 1, 1);
               else push_char(f, 8'h00, 1, 1);
            end
         clear_parser();
      end
   endtask

   // ---------------------------------------------------------------------------
   // stimulus tables
   // ---------------------------------------------------------------------------
   byte_item_type table_bytes [$];

   task automatic add_byte(input logic [7:0] d, input logic e = 0);
      byte_item_type it;
      it.data = d; it.tend = e;
      table_bytes.push_back(it);
   endtask

   task automatic add_text(input int len, input bit printable);
      for (int i = 0; i < len; i++)
         add_byte(printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255)));
      add_byte(8'h00);
   endtask

   // one random structure, mostly well formed
   task automatic add_structure();
      logic [7:0] ty, ln;
      int nstr;
      case ($urandom_range(0, 9))
         0, 1, 2: ty = sfx_pkg::TYPE_BIOS;
         3, 4:    ty = sfx_pkg::TYPE_SYSTEM;
         5, 6:    ty = sfx_pkg::TYPE_BOARD;
         default: ty = 8'($urandom);
      endcase
      ln = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 30))
                                       : ((ty == sfx_pkg::TYPE_SYSTEM) ? 8'h19 : 8'h08);
      add_byte(ty); add_byte(ln); add_byte(8'($urandom)); add_byte(8'($urandom));
      nstr = $urandom_range(0, 3);
      for (int i = 4; i < ln; i++) begin
         if (i == 4 || i == 5) add_byte(8'($urandom_range(0, nstr + 1)));
         else if ($urandom_range(0, 15) == 0) add_byte(8'hff);
         else add_byte(8'($urandom));
      end
      if (nstr == 0) add_byte(8'h00);
      for (int s = 0; s < nstr; s++)
         add_text(($urandom_range(0, 7) == 0) ? $urandom_range(40, 63)
                                              : $urandom_range(1, 6), 1);
      add_byte(8'h00);
   endtask

   // ---------------------------------------------------------------------------
   // receiver side checks
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      char_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.fid = rsp_tuser[2:0]; got.ch = rsp_tdata;
         got.last = rsp_tlast; got.cut = rsp_tuser[3];
         if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item fid %0d ch %h", got.fid, got.ch);
         end else begin
            want = pending_chars.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected fid %0d ch %h last %b cut %b, got fid %0d ch %h last %b cut %b",
                           want.fid, want.ch, want.last, want.cut,
                           got.fid, got.ch, got.last, got.cut);
            end
         end
      end
   end

   // receiver ready with random stalls, or a long hold-off
   always @(posedge clock)
      rsp_tready <= !reset && !hold_off && ($urandom_range(0, 99) >= recv_idle);

   initial begin
      #200000;
      $display("smbios_table_field_extractor_test NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      byte_item_type it;
      int n_sent, k, quiet;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: bios with both strings, long version truncated
      add_byte(sfx_pkg::TYPE_BIOS); add_byte(8'h08); add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h01); add_byte(8'h02); add_byte(8'h00); add_byte(8'h00);
      add_text(3, 1); add_text(40, 0); add_byte(8'h00);
      // system with uuid, same index twice for vendor and product
      add_byte(sfx_pkg::TYPE_SYSTEM); add_byte(8'h19); add_byte(8'hff); add_byte(8'hff);
      add_byte(8'h01); add_byte(8'h01); add_byte(8'h00); add_byte(8'h00);
      for (int i = 0; i < 16; i++) add_byte(8'(i * 17 + 1));
      add_byte(8'h00);
      add_text(2, 1); add_byte(8'h00);
      // table end inside a string with no field asked for
      add_byte(sfx_pkg::TYPE_BOARD); add_byte(8'h04); add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h41); add_byte(8'h42, 1);
      // short header then ignored bytes
      add_byte(sfx_pkg::TYPE_BIOS); add_byte(8'h02); add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h7f); add_byte(8'h80, 1);
      // table end inside a captured string: cut flag
      add_byte(sfx_pkg::TYPE_BOARD); add_byte(8'h06); add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h01); add_byte(8'h02); add_byte(8'h41); add_byte(8'h42, 1);

      n_sent = 0;
      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         if (phase_no == 1) begin send_idle = 71; recv_idle = 14; end
         if (phase_no == 2) begin send_idle = 0;  recv_idle = 0;  end
         while (n_sent < 155 * (phase_no + 1)) begin
            if (table_bytes.size() == 0) begin
               k = $urandom_range(1, 3);
               for (int s = 0; s < k; s++) add_structure();
               if ($urandom_range(0, 3) == 0) add_byte(8'($urandom), 1);
               else add_byte(8'h00, 1);
            end
            it = table_bytes.pop_front();
            while ($urandom_range(0, 99) < send_idle) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
            end
            req_tvalid <= 1'b1; req_tdata <= it.data; req_tlast <= it.tend;
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            predict_chars(it);
            n_sent++;
            // long receiver hold-off once, sender keeps offering
            if (n_sent == 40) begin
               hold_off = 1'b1;
               fork begin
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end join_none
            end
         end
      end
      while (table_bytes.size() > 0) begin
         it = table_bytes.pop_front();
         req_tvalid <= 1'b1; req_tdata <= it.data; req_tlast <= it.tend;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         predict_chars(it);
      end
      req_tvalid <= 1'b0;

      quiet = 0;
      while (pending_chars.size() > 0 && quiet < 20000) begin
         @(posedge clock);
         quiet++;
      end
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_chars.size() == 0)
         $display("smbios_table_field_extractor_test OK");
      else
         $display("smbios_table_field_extractor_test NOT OK");
      $finish;
   end

endmodule
